FILE: rtl/rv32_ex_pkg.sv
// ----------------------------------------------------------------------------
// rv32_ex_pkg
// Shared types and codes for the RV32IM execute unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rv32_ex_pkg;
  typedef enum logic [2:0] {
    CMD_LUI = 3'd0, CMD_AUIPC = 3'd1, CMD_JAL = 3'd2, CMD_JALR = 3'd3,
    CMD_OPIMM = 3'd4, CMD_OPREG = 3'd5, CMD_BRANCH = 3'd6, CMD_BAD = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    SEL_VAL, SEL_MULLO, SEL_MULHI, SEL_DIV, SEL_REM
  } sel_t;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [4:0] SHAMT_MASK = 5'h1f;

  typedef struct packed {
    logic        we;
    logic [4:0]  rd;
    logic        jmp;
    logic [31:0] tgt;
    logic        bad;
    sel_t        sel;
    logic [31:0] val;
  } ctl_t;
endpackage
`default_nettype wire

FILE: rtl/rv32_ex_div.sv
// ----------------------------------------------------------------------------
// rv32_ex_div
// Pipelined signed divider, 32 stages of one restoring step each.
// ----------------------------------------------------------------------------
`default_nettype none
module rv32_ex_div
  import rv32_ex_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [31:0] in_a,
  input  wire logic [31:0] in_b,
  output logic             out_valid,
  output logic [31:0]      out_quot,
  output logic [31:0]      out_rem
);
  localparam int Steps = 32;
  logic [Steps:0]       v_r;
  logic [31:0]          q_r  [Steps+1];
  logic [31:0]          r_r  [Steps+1];
  logic [31:0]          d_r  [Steps+1];
  logic [Steps:0]       nq_r, nr_r, dz_r, ov_r;
  logic [31:0]          a0_r [Steps+1];
  logic [32:0]          rem_nxt  [Steps];
  logic [32:0]          diff_nxt [Steps];

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[Steps-1:0], in_valid};
  end

  always_comb begin
    for (int i = 0; i < Steps; i++) begin
      rem_nxt[i]  = {r_r[i], q_r[i][31]};
      diff_nxt[i] = rem_nxt[i] - {1'b0, d_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    q_r[0]  <= in_a[31] ? (32'd0 - in_a) : in_a;
    d_r[0]  <= in_b[31] ? (32'd0 - in_b) : in_b;
    r_r[0]  <= '0;
    a0_r[0] <= in_a;
    nq_r[0] <= in_a[31] ^ in_b[31];
    nr_r[0] <= in_a[31];
    dz_r[0] <= (in_b == '0);
    ov_r[0] <= (in_a == 32'h8000_0000) && (in_b == 32'hffff_ffff);
    for (int i = 0; i < Steps; i++) begin
      if (!diff_nxt[i][32]) begin
        r_r[i+1] <= diff_nxt[i][31:0];
        q_r[i+1] <= {q_r[i][30:0], 1'b1};
      end else begin
        r_r[i+1] <= rem_nxt[i][31:0];
        q_r[i+1] <= {q_r[i][30:0], 1'b0};
      end
      d_r[i+1]  <= d_r[i];
      a0_r[i+1] <= a0_r[i];
      nq_r[i+1] <= nq_r[i];
      nr_r[i+1] <= nr_r[i];
      dz_r[i+1] <= dz_r[i];
      ov_r[i+1] <= ov_r[i];
    end
  end

  always_comb begin
    out_valid = v_r[Steps];
    if (dz_r[Steps]) begin
      out_quot = 32'hffff_ffff;
      out_rem  = a0_r[Steps];
    end else if (ov_r[Steps]) begin
      out_quot = 32'h8000_0000;
      out_rem  = '0;
    end else begin
      out_quot = nq_r[Steps] ? (32'd0 - q_r[Steps]) : q_r[Steps];
      out_rem  = nr_r[Steps] ? (32'd0 - r_r[Steps]) : r_r[Steps];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/rv32im_execute_unit_core.sv
// ----------------------------------------------------------------------------
// rv32im_execute_unit_core
// RV32IM execute stage: decode, ALU, multiply and divide in one pipeline.
// ----------------------------------------------------------------------------
//  channel  | ports                        | handshake
//  request  | in_* fields                  | start && !busy
//  result   | out_* fields                 | out_strobe, one cycle
//
//  Every request passes through the same pipeline from start to out_strobe;
//  its depth is set by the 32 one-bit stages of the divider, and all classes share that depth.
//  One request may enter every cycle; busy stays low.
//  Synchronous active-low reset empties the pipeline.
`default_nettype none
module rv32im_execute_unit_core
  import rv32_ex_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_command,
  input  wire logic [2:0]  in_funct_three,
  input  wire logic [6:0]  in_funct_seven,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  input  wire logic [31:0] in_branch_offset,
  input  wire logic [31:0] in_current_pc,
  input  wire logic [4:0]  in_dest_index,
  output logic             out_strobe,
  output logic             out_write_enable,
  output logic [4:0]       out_write_index,
  output logic [31:0]      out_write_value,
  output logic             out_jump_taken,
  output logic [31:0]      out_jump_target,
  output logic             out_illegal
);
  localparam int Depth = 34;
  ctl_t        c_nxt;
  ctl_t        c_r [Depth];
  logic [Depth-1:0] v_r;
  logic [31:0] a_r, b_r;
  logic [63:0] ss_r, su_r, us_r, uu_r;
  logic [63:0] mh_r [2:Depth-1];
  logic        dv_v;
  logic [31:0] dq, drm;
  logic [4:0]  sh;
  logic        lts, ltu;

  assign busy = 1'b0;

  always_comb begin
    sh  = in_operand_b[4:0] & SHAMT_MASK;
    lts = $signed(in_operand_a) < $signed(in_operand_b);
    ltu = in_operand_a < in_operand_b;
    c_nxt = '{we: 1'b1, rd: in_dest_index, jmp: 1'b0, tgt: '0, bad: 1'b0,
              sel: SEL_VAL, val: '0};
    unique case (cmd_t'(in_command))
      CMD_LUI:   c_nxt.val = in_operand_a;
      CMD_AUIPC: c_nxt.val = in_current_pc + in_operand_a;
      CMD_JAL: begin
        c_nxt.val = in_current_pc + 32'd4;
        c_nxt.jmp = 1'b1;
        c_nxt.tgt = in_current_pc + in_operand_a;
      end
      CMD_JALR: begin
        c_nxt.val = in_current_pc + 32'd4;
        c_nxt.jmp = 1'b1;
        c_nxt.tgt = (in_operand_a + in_operand_b) & ~32'd1;
      end
      CMD_OPIMM: begin
        case (in_funct_three)
          3'd0: c_nxt.val = in_operand_a + in_operand_b;
          3'd1: c_nxt.val = in_operand_a << sh;
          3'd3: c_nxt.val = {31'd0, ltu};
          3'd4: c_nxt.val = in_operand_a ^ in_operand_b;
          3'd5: c_nxt.val = (in_funct_seven == F7_ALT) ?
                  32'($signed(in_operand_a) >>> sh) : in_operand_a >> sh;
          3'd7: c_nxt.val = in_operand_a & in_operand_b;
          default: c_nxt.bad = 1'b1;
        endcase
      end
      CMD_OPREG: begin
        if (in_funct_seven == F7_BASE) begin
          case (in_funct_three)
            3'd0: c_nxt.val = in_operand_a + in_operand_b;
            3'd1: c_nxt.val = in_operand_a << sh;
            3'd2: c_nxt.val = {31'd0, lts};
            3'd3: c_nxt.val = {31'd0, ltu};
            3'd4: c_nxt.val = in_operand_a ^ in_operand_b;
            3'd5: c_nxt.val = in_operand_a >> sh;
            3'd6: c_nxt.val = in_operand_a | in_operand_b;
            default: c_nxt.val = in_operand_a & in_operand_b;
          endcase
        end else if (in_funct_seven == F7_ALT) begin
          if (in_funct_three == 3'd0) c_nxt.val = in_operand_a - in_operand_b;
          else if (in_funct_three == 3'd5)
            c_nxt.val = 32'($signed(in_operand_a) >>> sh);
          else c_nxt.bad = 1'b1;
        end else if (in_funct_seven == F7_MULDIV) begin
          case (in_funct_three)
            3'd0: c_nxt.sel = SEL_MULLO;
            3'd1: c_nxt.sel = SEL_MULHI;
            3'd4: c_nxt.sel = SEL_DIV;
            3'd6: c_nxt.sel = SEL_REM;
            default: c_nxt.bad = 1'b1;
          endcase
        end else c_nxt.bad = 1'b1;
      end
      CMD_BRANCH: begin
        c_nxt.we = 1'b0;
        case (in_funct_three)
          3'd0: c_nxt.jmp = in_operand_a == in_operand_b;
          3'd1: c_nxt.jmp = in_operand_a != in_operand_b;
          3'd4: c_nxt.jmp = lts;
          3'd5: c_nxt.jmp = !lts;
          default: c_nxt.bad = 1'b1;
        endcase
        if (c_nxt.jmp) c_nxt.tgt = in_current_pc + in_branch_offset;
      end
      default: c_nxt.bad = 1'b1;
    endcase
    if (c_nxt.bad) begin
      c_nxt.we = 1'b0; c_nxt.jmp = 1'b0; c_nxt.tgt = '0; c_nxt.val = '0;
      c_nxt.sel = SEL_VAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= {v_r[Depth-2:0], start};
  end

  always_ff @(posedge clk) begin
    c_r[0] <= c_nxt;
    a_r    <= in_operand_a;
    b_r    <= in_operand_b;
    for (int i = 1; i < Depth; i++) c_r[i] <= c_r[i-1];
  end

  // split 32x32 product into four 16x16 parts, then sum
  always_ff @(posedge clk) begin
    uu_r <= {32'd0, {16'd0, a_r[15:0]} * {16'd0, b_r[15:0]}};
    us_r <= {32'd0, {16'd0, a_r[15:0]} * {16'd0, b_r[31:16]}};
    su_r <= {32'd0, {16'd0, a_r[31:16]} * {16'd0, b_r[15:0]}};
    ss_r <= {32'd0, {16'd0, a_r[31:16]} * {16'd0, b_r[31:16]}};
  end

  logic [63:0] prod_u;
  logic [31:0] hi_fix;
  logic [31:0] a_d_r, b_d_r;
  always_ff @(posedge clk) begin
    a_d_r <= a_r;
    b_d_r <= b_r;
  end
  always_comb begin
    prod_u = uu_r + (us_r << 16) + (su_r << 16) + (ss_r << 32);
    hi_fix = prod_u[63:32] - (a_d_r[31] ? b_d_r : 32'd0)
                           - (b_d_r[31] ? a_d_r : 32'd0);
  end

  always_ff @(posedge clk) begin
    mh_r[2] <= {hi_fix, prod_u[31:0]};
    for (int i = 3; i < Depth; i++) mh_r[i] <= mh_r[i-1];
  end

  rv32_ex_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[0]),
    .in_a      (a_r),
    .in_b      (b_r),
    .out_valid (dv_v),
    .out_quot  (dq),
    .out_rem   (drm)
  );

  ctl_t ct;
  logic [31:0] res;
  always_comb begin
    ct = c_r[Depth-1];
    case (ct.sel)
      SEL_MULLO: res = mh_r[Depth-1][31:0];
      SEL_MULHI: res = mh_r[Depth-1][63:32];
      SEL_DIV:   res = dq;
      SEL_REM:   res = drm;
      default:   res = ct.val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= v_r[Depth-1] && dv_v;
    out_write_enable <= ct.we;
    out_write_index  <= ct.rd;
    out_write_value  <= ct.we ? res : 32'd0;
    out_jump_taken   <= ct.jmp;
    out_jump_target  <= ct.tgt;
    out_illegal      <= ct.bad;
  end
endmodule
`default_nettype wire

FILE: rtl/rv32_ex_check.sv
// ----------------------------------------------------------------------------
// rv32_ex_check
// Port-level checks for the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module rv32_ex_check (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        busy,
  input wire logic        out_strobe,
  input wire logic        out_write_enable,
  input wire logic        out_jump_taken,
  input wire logic [31:0] out_jump_target,
  input wire logic [31:0] out_write_value,
  input wire logic        out_illegal
);
  a_nobusy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_ill: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_illegal |-> !out_write_enable && !out_jump_taken)
    else $error("illegal request wrote or jumped");
  a_tgt: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_jump_taken |-> out_jump_target == 32'd0)
    else $error("target without jump");
  a_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_write_enable |-> out_write_value == 32'd0)
    else $error("value without write");
endmodule

bind rv32im_execute_unit_core rv32_ex_check u_check (.*);
`default_nettype wire

FILE: verif/rv32im_execute_unit_core_checker.sv
// ----------------------------------------------------------------------------
// rv32im_execute_unit_core_checker
// Watches requests and results of the execute unit, predicts each result from
// the request fields and compares them in order; counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none
module rv32im_execute_unit_core_checker
  import rv32_ex_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [2:0]  in_command,
  input  wire logic [2:0]  in_funct_three,
  input  wire logic [6:0]  in_funct_seven,
  input  wire logic [31:0] in_operand_a,
  input  wire logic [31:0] in_operand_b,
  input  wire logic [31:0] in_branch_offset,
  input  wire logic [31:0] in_current_pc,
  input  wire logic [4:0]  in_dest_index,
  input  wire logic        out_strobe,
  input  wire logic        out_write_enable,
  input  wire logic [4:0]  out_write_index,
  input  wire logic [31:0] out_write_value,
  input  wire logic        out_jump_taken,
  input  wire logic [31:0] out_jump_target,
  input  wire logic        out_illegal,
  output int               fail_count,
  output int               pending,
  output int               result_count
);

  typedef struct packed {
    logic        we;
    logic [4:0]  rd;
    logic [31:0] val;
    logic        jmp;
    logic [31:0] tgt;
    logic        bad;
  } exec_result_t;

  exec_result_t expected_results[$];

  function automatic logic [31:0] signed_divide(logic [31:0] a, logic [31:0] b,
                                                logic want_rem);
    if (b == 32'd0) return want_rem ? a : 32'hffff_ffff;
    if (a == 32'h8000_0000 && b == 32'hffff_ffff) return want_rem ? 32'd0 : a;
    return want_rem ? $signed(a) % $signed(b) : $signed(a) / $signed(b);
  endfunction

  function automatic exec_result_t execute_instruction(
      logic [2:0] cmd, logic [2:0] f3, logic [6:0] f7, logic [31:0] a,
      logic [31:0] b, logic [31:0] off, logic [31:0] pc, logic [4:0] rd);
    exec_result_t r;
    logic [4:0]  sh;
    logic [63:0] prod;
    r = '0;
    r.rd = rd;
    sh = b[4:0] & SHAMT_MASK;
    prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    case (cmd_t'(cmd))
      CMD_LUI: begin r.we = 1; r.val = a; end
      CMD_AUIPC: begin r.we = 1; r.val = pc + a; end
      CMD_JAL: begin r.we = 1; r.val = pc + 4; r.jmp = 1; r.tgt = pc + a; end
      CMD_JALR: begin
        r.we = 1; r.val = pc + 4; r.jmp = 1; r.tgt = (a + b) & ~32'd1;
      end
      CMD_OPIMM: begin
        r.we = 1;
        case (f3)
          3'd0: r.val = a + b;
          3'd1: r.val = a << sh;
          3'd3: r.val = {31'd0, a < b};
          3'd4: r.val = a ^ b;
          3'd5: r.val = (f7 == F7_ALT) ? 32'($signed(a) >>> sh) : a >> sh;
          3'd7: r.val = a & b;
          default: r.bad = 1;
        endcase
      end
      CMD_OPREG: begin
        r.we = 1;
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: r.val = a + b;
            3'd1: r.val = a << sh;
            3'd2: r.val = {31'd0, $signed(a) < $signed(b)};
            3'd3: r.val = {31'd0, a < b};
            3'd4: r.val = a ^ b;
            3'd5: r.val = a >> sh;
            3'd6: r.val = a | b;
            default: r.val = a & b;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == 3'd0) r.val = a - b;
          else if (f3 == 3'd5) r.val = 32'($signed(a) >>> sh);
          else r.bad = 1;
        end else if (f7 == F7_MULDIV) begin
          case (f3)
            3'd0: r.val = prod[31:0];
            3'd1: r.val = prod[63:32];
            3'd4: r.val = signed_divide(a, b, 1'b0);
            3'd6: r.val = signed_divide(a, b, 1'b1);
            default: r.bad = 1;
          endcase
        end else begin
          r.bad = 1;
        end
      end
      CMD_BRANCH: begin
        case (f3)
          3'd0: r.jmp = (a == b);
          3'd1: r.jmp = (a != b);
          3'd4: r.jmp = $signed(a) < $signed(b);
          3'd5: r.jmp = !($signed(a) < $signed(b));
          default: r.bad = 1;
        endcase
        if (r.jmp) r.tgt = pc + off;
      end
      default: r.bad = 1;
    endcase
    if (r.bad) begin
      r.we = 0; r.val = 0; r.jmp = 0; r.tgt = 0;
    end
    if (!r.we) r.val = 0;
    if (!r.jmp) r.tgt = 0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    result_count = 0;
  end

  always @(posedge clk) begin
    exec_result_t want;
    if (rst_n && out_strobe) begin
      result_count++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_write_value, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_write_enable !== want.we)
          report_mismatch("write_enable", out_write_enable, want.we);
        if (out_write_index !== want.rd)
          report_mismatch("write_index", out_write_index, want.rd);
        if (out_write_value !== want.val)
          report_mismatch("write_value", out_write_value, want.val);
        if (out_jump_taken !== want.jmp)
          report_mismatch("jump_taken", out_jump_taken, want.jmp);
        if (out_jump_target !== want.tgt)
          report_mismatch("jump_target", out_jump_target, want.tgt);
        if (out_illegal !== want.bad)
          report_mismatch("illegal", out_illegal, want.bad);
      end
    end
    if (rst_n && start && !busy)
      expected_results.push_back(execute_instruction(in_command, in_funct_three,
          in_funct_seven, in_operand_a, in_operand_b, in_branch_offset,
          in_current_pc, in_dest_index));
    pending = expected_results.size();
  end
endmodule
`default_nettype wire

FILE: verif/rv32im_execute_unit_core_tb.sv
// ----------------------------------------------------------------------------
// rv32im_execute_unit_core_tb
// Drives directed and random instructions with random gaps into the execute
// unit and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none
module rv32im_execute_unit_core_tb;
  import rv32_ex_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_command = '0;
  logic [2:0]  in_funct_three = '0;
  logic [6:0]  in_funct_seven = '0;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic [31:0] in_branch_offset = '0;
  logic [31:0] in_current_pc = '0;
  logic [4:0]  in_dest_index = '0;
  logic        out_strobe, out_write_enable, out_jump_taken, out_illegal;
  logic [4:0]  out_write_index;
  logic [31:0] out_write_value, out_jump_target;
  int          fail_count, pending, result_count;
  int          sent;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  rv32im_execute_unit_core dut (.*);
  rv32im_execute_unit_core_checker checker_i (.*);

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(logic [2:0] cmd, logic [2:0] f3, logic [6:0] f7,
                              logic [31:0] a, logic [31:0] b);
    in_command <= cmd;
    in_funct_three <= f3;
    in_funct_seven <= f7;
    in_operand_a <= a;
    in_operand_b <= b;
    in_branch_offset <= $urandom;
    in_current_pc <= $urandom;
    in_dest_index <= 5'($urandom);
    start <= 1;
    do @(posedge clk); while (busy);
    sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic random_request();
    logic [6:0] f7;
    logic [2:0] cmd;
    case ($urandom_range(0, 5))
      0: f7 = 7'($urandom);
      1: f7 = F7_ALT;
      2: f7 = F7_MULDIV;
      default: f7 = F7_BASE;
    endcase
    cmd = ($urandom_range(0, 2) == 0) ? 3'($urandom) : CMD_OPREG;
    send_request(cmd, 3'($urandom), f7, pick_operand(), pick_operand());
  endtask

  initial begin
    int waited;
    sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed: each class, extremes, divide corner cases, illegal encodings
    send_request(CMD_LUI, 3'd0, F7_BASE, 32'hffff_f000, 32'd0);
    send_request(CMD_AUIPC, 3'd0, F7_BASE, 32'hffff_ffff, 32'd0);
    send_request(CMD_JAL, 3'd0, F7_BASE, 32'h8000_0000, 32'd0);
    send_request(CMD_JALR, 3'd0, F7_BASE, 32'h7fff_ffff, 32'h0000_0002);
    send_request(CMD_OPIMM, 3'd5, F7_ALT, 32'h8000_0000, 32'hffff_ffff);
    send_request(CMD_OPIMM, 3'd5, 7'h7f, 32'h8000_0000, 32'd31);
    send_request(CMD_OPIMM, 3'd2, F7_BASE, 32'd1, 32'd2);
    send_request(CMD_OPREG, 3'd4, F7_MULDIV, 32'd7, 32'd0);
    send_request(CMD_OPREG, 3'd6, F7_MULDIV, 32'd7, 32'd0);
    send_request(CMD_OPREG, 3'd4, F7_MULDIV, 32'h8000_0000, 32'hffff_ffff);
    send_request(CMD_OPREG, 3'd6, F7_MULDIV, 32'h8000_0000, 32'hffff_ffff);
    send_request(CMD_OPREG, 3'd1, F7_MULDIV, 32'h8000_0000, 32'h8000_0000);
    send_request(CMD_OPREG, 3'd6, F7_MULDIV, 32'hffff_fff9, 32'd2);
    send_request(CMD_OPREG, 3'd1, F7_BASE, 32'd1, 32'hffff_ffff);
    send_request(CMD_OPREG, 3'd3, F7_ALT, 32'd1, 32'd2);
    send_request(CMD_OPREG, 3'd2, F7_MULDIV, 32'd1, 32'd2);
    send_request(CMD_OPREG, 3'd0, 7'h7f, 32'd1, 32'd2);
    send_request(CMD_BRANCH, 3'd0, F7_BASE, 32'd5, 32'd5);
    send_request(CMD_BRANCH, 3'd1, F7_BASE, 32'd5, 32'd5);
    send_request(CMD_BRANCH, 3'd4, F7_BASE, 32'h8000_0000, 32'd0);
    send_request(CMD_BRANCH, 3'd5, F7_BASE, 32'h8000_0000, 32'd0);
    send_request(CMD_BRANCH, 3'd2, F7_BASE, 32'd0, 32'd0);
    send_request(CMD_BAD, 3'd0, F7_BASE, 32'd1, 32'd1);
    for (int f3 = 0; f3 < 8; f3++)
      for (int k = 0; k < 3; k++)
        send_request(CMD_OPREG, 3'(f3),
                     k == 0 ? F7_BASE : (k == 1 ? F7_ALT : F7_MULDIV),
                     pick_operand(), pick_operand());
    repeat (750) begin
      idle_gap();
      random_request();
    end
    start <= 0;
    waited = 0;
    while (pending != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    $display("sent %0d instructions over all classes, %0d results checked",
             sent, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[rv32im_execute_unit_core] OK");
    end else begin
      $display("[rv32im_execute_unit_core] ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[rv32im_execute_unit_core] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
